// ===== hw/rtl/bit_table_rect_fill_core_defines.svh =====
// Assertion macros for the bit table rectangle fill core.
`ifndef BIT_TABLE_RECT_FILL_CORE_DEFINES_SVH
`define BIT_TABLE_RECT_FILL_CORE_DEFINES_SVH

// Same-cycle implication check.
`define BTRF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btrf: same-cycle check failed");

// Next-cycle implication check.
`define BTRF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btrf: next-cycle check failed");

`endif

// ===== hw/rtl/btrf_pkg.sv =====
// Shared types, codes and constants of the bit table rectangle fill core.
package btrf_pkg;

   localparam int DIM_W          = 7;
   localparam int CMD_W          = 3;
   localparam int CSR_IDX_W      = 2;
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int DIM_RESET      = 64;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_READ_BIT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_BIT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INVERT_BIT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FILL_RECT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INVERT_RECT = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_HEIGHT = 2'd1;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_READ,
      OP_WRITE,
      OP_INVERT
   } btrf_op_type;

   // One classified command: a span of columns applied to a run of rows.
   typedef struct packed {
      btrf_op_type      op;
      logic             err;
      logic             value;
      logic [DIM_W-1:0] col_lo;
      logic [DIM_W-1:0] col_cnt;
      logic [DIM_W-1:0] row_lo;
      logic [DIM_W-1:0] row_cnt;
   } btrf_job_type;

endpackage

// ===== hw/rtl/btrf_req_if.sv =====
// Command channel: valid/ready handshake with the command fields.
interface btrf_req_if
   import btrf_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [DIM_W-1:0] pos_x;
   logic [DIM_W-1:0] pos_y;
   logic [DIM_W-1:0] rect_width;
   logic [DIM_W-1:0] rect_height;
   logic             fill_value;

   modport source (
      output valid, cmd, pos_x, pos_y, rect_width, rect_height, fill_value,
      input  ready
   );
   modport sink (
      input  valid, cmd, pos_x, pos_y, rect_width, rect_height, fill_value,
      output ready
   );
endinterface

// ===== hw/rtl/btrf_rsp_if.sv =====
// Result channel: valid/ready handshake with the result fields.
interface btrf_rsp_if
   import btrf_pkg::*;
();
   logic valid;
   logic ready;
   logic read_bit;
   logic range_error;

   modport source (
      output valid, read_bit, range_error,
      input  ready
   );
   modport sink (
      input  valid, read_bit, range_error,
      output ready
   );
endinterface

// ===== hw/rtl/btrf_csr_if.sv =====
// Configuration write channel: valid/ready handshake with index and data.
interface btrf_csr_if
   import btrf_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== hw/rtl/bit_table_rect_fill_core.sv =====
// Bit table with point and rectangle commands. Point commands run in the row engine as a memory
// read, then a modify-write; rectangles read their first row, then walk one row per cycle through
// the single read and write port. Rejected and empty commands go straight to the result register
// once it is free. A 2-entry queue lets commands enter while one runs. Synchronous reset restores
// both dimensions to 64 (or to the table maximum if smaller) and starts a clearing pass over the
// rows; commands are held off until it ends, configuration writes are taken throughout.
`include "bit_table_rect_fill_core_defines.svh"

module bit_table_rect_fill_core
   import btrf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   btrf_req_if.sink   req_port,
   btrf_rsp_if.source rsp_port,
   btrf_csr_if.sink   csr_port
);

   localparam int DIM_MAX        = (2 ** DIM_W) - 1;
   localparam int WIDTH_CAP_INT  = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
   localparam int HEIGHT_CAP_INT = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
   localparam logic [DIM_W-1:0] WIDTH_CAP  = DIM_W'(WIDTH_CAP_INT);
   localparam logic [DIM_W-1:0] HEIGHT_CAP = DIM_W'(HEIGHT_CAP_INT);
   localparam logic [DIM_W-1:0] WIDTH_RST  =
      DIM_W'((WIDTH_CAP_INT > DIM_RESET) ? DIM_RESET : WIDTH_CAP_INT);
   localparam logic [DIM_W-1:0] HEIGHT_RST =
      DIM_W'((HEIGHT_CAP_INT > DIM_RESET) ? DIM_RESET : HEIGHT_CAP_INT);

   logic [DIM_W-1:0] table_width_ff;
   logic [DIM_W-1:0] table_width_in;
   logic [DIM_W-1:0] table_height_ff;
   logic [DIM_W-1:0] table_height_in;
   logic [DIM_W-1:0] width_clamped;
   logic [DIM_W-1:0] height_clamped;
   logic             csr_xfer;
   logic             dims_ok;

   logic         push_valid;
   logic         push_ready;
   btrf_job_type push_job;
   logic         pop_valid;
   logic         pop_ready;
   btrf_job_type pop_job;
   logic         clear_done;

   assign csr_port.ready = 1'b1;
   assign csr_xfer       = csr_port.valid && csr_port.ready;

   always_comb begin
      // zero becomes one, anything above the table maximum becomes the maximum
      if (csr_port.data == '0) begin
         width_clamped  = DIM_W'(1);
         height_clamped = DIM_W'(1);
      end else begin
         width_clamped  = (csr_port.data > WIDTH_CAP) ? WIDTH_CAP : csr_port.data;
         height_clamped = (csr_port.data > HEIGHT_CAP) ? HEIGHT_CAP : csr_port.data;
      end

      table_width_in  = table_width_ff;
      table_height_in = table_height_ff;
      if (csr_xfer) begin
         unique case (csr_port.index)
            CSR_TABLE_WIDTH:  table_width_in  = width_clamped;
            CSR_TABLE_HEIGHT: table_height_in = height_clamped;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_width_ff  <= WIDTH_RST;
         table_height_ff <= HEIGHT_RST;
      end else begin
         table_width_ff  <= table_width_in;
         table_height_ff <= table_height_in;
      end
   end

   btrf_front u_front (
      .req_port     (req_port),
      .table_width  (table_width_ff),
      .table_height (table_height_ff),
      .accept_en    (clear_done),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_job     (push_job)
   );

   btrf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   btrf_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .clear_done (clear_done),
      .rsp_port   (rsp_port)
   );

   assign dims_ok = (table_width_ff != '0) && (table_width_ff <= WIDTH_CAP)
                 && (table_height_ff != '0) && (table_height_ff <= HEIGHT_CAP);

   `BTRF_ASSERT_IMP(a_no_cmd_during_clear, clock, reset, !clear_done, !req_port.ready)
   `BTRF_ASSERT_NXT(a_clear_stays_done, clock, reset, clear_done, clear_done)
   `BTRF_ASSERT_IMP(a_dims_legal, clock, reset, 1'b1, dims_ok)
   `BTRF_ASSERT_IMP(a_no_bit_with_error, clock, reset, rsp_port.valid && rsp_port.read_bit, !rsp_port.range_error)

endmodule

// ===== hw/rtl/btrf_front.sv =====
// Command front end: range check and classification into row jobs.
module btrf_front
   import btrf_pkg::*;
(
   btrf_req_if.sink          req_port,
   input  logic [DIM_W-1:0]  table_width,
   input  logic [DIM_W-1:0]  table_height,
   input  logic              accept_en,
   output logic              push_valid,
   input  logic              push_ready,
   output btrf_job_type      push_job
);

   logic        pt_err;
   logic        rect_err;
   logic        rect_empty;
   btrf_op_type pt_op;

   always_comb begin
      pt_err   = (req_port.pos_x >= table_width) || (req_port.pos_y >= table_height);
      // the differences may wrap, but then the edge compares already flag the error
      rect_err = (req_port.pos_x > table_width) || (req_port.pos_y > table_height)
              || (req_port.rect_width > (table_width - req_port.pos_x))
              || (req_port.rect_height > (table_height - req_port.pos_y));
      rect_empty = (req_port.rect_width == '0) || (req_port.rect_height == '0);
      pt_op = (req_port.cmd == CMD_READ_BIT)  ? OP_READ  :
              (req_port.cmd == CMD_WRITE_BIT) ? OP_WRITE : OP_INVERT;

      push_job.op      = OP_NONE;
      push_job.err     = 1'b0;
      push_job.value   = req_port.fill_value;
      push_job.col_lo  = req_port.pos_x;
      push_job.col_cnt = DIM_W'(1);
      push_job.row_lo  = req_port.pos_y;
      push_job.row_cnt = DIM_W'(1);

      unique case (req_port.cmd) inside
         CMD_READ_BIT, CMD_WRITE_BIT, CMD_INVERT_BIT: begin
            if (pt_err) begin
               push_job.err = 1'b1;
            end else begin
               push_job.op = pt_op;
            end
         end
         CMD_FILL_RECT, CMD_INVERT_RECT: begin
            if (rect_err) begin
               push_job.err = 1'b1;
            end else if (!rect_empty) begin
               push_job.op      = (req_port.cmd == CMD_FILL_RECT) ? OP_WRITE : OP_INVERT;
               push_job.col_cnt = req_port.rect_width;
               push_job.row_cnt = req_port.rect_height;
            end
         end
         default: begin
         end
      endcase
   end

   assign push_valid     = req_port.valid && accept_en;
   assign req_port.ready = push_ready && accept_en;

endmodule

// ===== hw/rtl/btrf_queue.sv =====
// Short job queue between the front end and the row engine.
module btrf_queue
   import btrf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  btrf_job_type push_job,
   output logic         pop_valid,
   input  logic         pop_ready,
   output btrf_job_type pop_job
);

   btrf_job_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              push_xfer;
   logic              pop_xfer;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign push_xfer  = push_valid && push_ready;
   assign pop_xfer   = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push_xfer) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_xfer) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_xfer) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_xfer && !pop_xfer) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_xfer && !push_xfer) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/btrf_back.sv =====
// Row engine: clearing pass, row read-modify-write walk and result register.
module btrf_back
   import btrf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  btrf_job_type pop_job,
   output logic         clear_done,
   btrf_rsp_if.source   rsp_port
);

   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CMP_W = DIM_W + 1;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_HEIGHT - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [DIM_W-1:0]   left_ff;
   btrf_job_type       job_ff;
   logic               res_bit_ff;
   logic               rsp_valid_ff;
   logic               rsp_bit_ff;
   logic               rsp_err_ff;

   logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] rd_data_ff;

   logic                 out_free;
   logic                 rsp_load;
   logic [MAX_WIDTH-1:0] mask;
   logic [MAX_WIDTH-1:0] new_row;
   logic                 last_row;
   logic                 run_bit;
   logic                 mem_wen;
   logic [ROW_W-1:0]     mem_raddr;
   logic [MAX_WIDTH-1:0] mem_wdata;
   logic [CMP_W-1:0]     col_end;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_port.ready;
      col_end  = {1'b0, job_ff.col_lo} + {1'b0, job_ff.col_cnt};
      for (int i = 0; i < MAX_WIDTH; i++) begin
         mask[i] = (CMP_W'(i) >= {1'b0, job_ff.col_lo}) && (CMP_W'(i) < col_end);
      end
      if (job_ff.op == OP_INVERT) begin
         new_row = rd_data_ff ^ mask;
      end else if (job_ff.value) begin
         new_row = rd_data_ff | mask;
      end else begin
         new_row = rd_data_ff & ~mask;
      end
      last_row = (left_ff == DIM_W'(1));
      run_bit  = (job_ff.op == OP_READ) && (|(rd_data_ff & mask));

      // fetch the head job's first row from idle, otherwise the row after the current one
      mem_raddr = (state_ff == ST_IDLE) ? ROW_W'(pop_job.row_lo) : row_ff + 1'b1;
      mem_wen   = (state_ff == ST_CLEAR)
               || ((state_ff == ST_RUN)
                   && ((job_ff.op == OP_WRITE) || (job_ff.op == OP_INVERT)));
      mem_wdata = (state_ff == ST_CLEAR) ? '0 : new_row;

      pop_ready = (state_ff == ST_IDLE) && ((pop_job.op != OP_NONE) || out_free);

      // load the result register when a job finishes and the register is free
      rsp_load = (pop_valid && pop_ready && (pop_job.op == OP_NONE))
              || ((state_ff == ST_RUN) && last_row && out_free)
              || ((state_ff == ST_DONE) && out_free);
   end

   always_ff @(posedge clock) begin
      if (mem_wen) begin
         mem[row_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_port.ready);
         unique case (state_ff)
            ST_CLEAR: begin
               row_ff <= row_ff + 1'b1;
               if (row_ff == LAST_ROW) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (pop_valid && pop_ready) begin
                  job_ff  <= pop_job;
                  row_ff  <= ROW_W'(pop_job.row_lo);
                  left_ff <= pop_job.row_cnt;
                  if (pop_job.op == OP_NONE) begin
                     rsp_bit_ff   <= 1'b0;
                     rsp_err_ff   <= pop_job.err;
                  end else begin
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               row_ff  <= row_ff + 1'b1;
               left_ff <= left_ff - 1'b1;
               if (last_row) begin
                  if (out_free) begin
                     rsp_bit_ff   <= run_bit;
                     rsp_err_ff   <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     res_bit_ff <= run_bit;
                     state_ff   <= ST_DONE;
                  end
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_bit_ff   <= res_bit_ff;
                  rsp_err_ff   <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign clear_done           = (state_ff != ST_CLEAR);
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.read_bit    = rsp_bit_ff;
   assign rsp_port.range_error = rsp_err_ff;

endmodule
